@@ hdl/blfs_pkg.sv @@
// Types and constants shared by the block lacing frame splitter.
`timescale 1ns / 1ps
`default_nettype none
package blfs_pkg;
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_XIPH  = 2'd1;
  localparam logic [1:0] MODE_FIXED = 2'd2;
  localparam logic [1:0] MODE_EBML  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_MANY = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  localparam logic [7:0] XIPH_CONT = 8'd255;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_COUNT  = 9'b000000010,
    PH_XSIZE  = 9'b000000100,
    PH_VFIRST = 9'b000001000,
    PH_VREST  = 9'b000010000,
    PH_STORE  = 9'b000100000,
    PH_DIV    = 9'b001000000,
    PH_EMIT   = 9'b010000000,
    PH_ERR    = 9'b100000000
  } phase_t;
endpackage
`default_nettype wire

@@ hdl/blfs_size_ram.sv @@
// Lace size store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module blfs_size_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 25
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/block_lacing_frame_splitter.sv @@
// Block lacing frame splitter: header parser, size store and frame emitter.
// Block-start and header-byte requests are taken while busy is low. Header bytes that do
// not complete a size can follow back to back; a byte that completes a size raises busy
// while the size goes into the store. Once the header is complete the frame list streams
// out, each frame taking a store read, then an offset add, with busy high until the last
// frame leaves. Fixed lacing first runs a restoring divider. A no-lacing block skips the
// header and shows its single frame after the emitter's read and add steps; a count whose
// frame total (count+1) exceeds MAX_LACES moves to an error state that then gives one
// too-many result. The receiver cannot stall; out_valid marks each result for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module block_lacing_frame_splitter
  import blfs_pkg::*;
#(
  parameter int MAX_LACES = 64,
  parameter int SIZE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [1:0]  in_lace_mode,
  input  wire logic [23:0] in_block_len,
  input  wire logic [7:0]  in_header_byte,
  output logic             out_valid,
  output logic [5:0]       out_frame_index,
  output logic [23:0]      out_frame_offset,
  output logic [23:0]      out_frame_size,
  output logic             out_last,
  output logic [1:0]       out_status
);
  localparam int AW = (MAX_LACES > 1) ? $clog2(MAX_LACES) : 1;
  localparam int CW = AW + 1;          // count width, holds MAX_LACES
  localparam int SW = SIZE_BITS;
  localparam logic [SW-1:0] LEN_MASK = {SW{1'b1}};
  localparam logic [CW-1:0] MAXL = CW'(MAX_LACES);
  // running ebml size kept to 64 bits signed, saturated at +-2^62
  localparam logic signed [63:0] RUN_LIM = 64'sh4000_0000_0000_0000;

  phase_t phase_r, phase_nxt;
  logic [1:0]    mode_r;
  logic [SW-1:0] tlen_r;
  logic [CW-1:0] ftot_r, fpar_r;
  logic [SW-1:0] hlen_r;
  logic [55:0]   acc_r;
  logic [2:0]    vleft_r;
  logic [3:0]    vlen_r;
  logic signed [63:0] run_r;
  // pending size for the store
  logic [SW-1:0] psize_r;
  logic          pbad_r;
  // divider
  logic [SW-1:0] quo_r, rem_r, dvd_r;
  logic [8:0]    dcnt_r;
  logic [8:0]    divn_r;
  // emitter
  logic [CW-1:0] ei_r;
  logic          estep_r;   // 0: read issued, 1: data ready
  logic [SW:0]   off_r;
  logic          stuck_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW:0]   wdata, rdata;

  blfs_size_ram #(.DEPTH(MAX_LACES), .AW(AW), .DW(SW + 1)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (phase_r != PH_IDLE) && (phase_r != PH_COUNT) &&
                (phase_r != PH_XSIZE) && (phase_r != PH_VFIRST) &&
                (phase_r != PH_VREST);
  assign we    = (phase_r == PH_STORE) && (fpar_r < MAXL);
  assign waddr = fpar_r[AW-1:0];
  assign wdata = {pbad_r, psize_r};
  assign raddr = ei_r[AW-1:0];

  // ebml vint parse helpers
  logic [3:0]  vl;
  logic [7:0]  vmask;
  logic [55:0] vacc;
  logic signed [63:0] bias, vval, vsub, vfinal;
  always_comb begin
    vl = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (in_header_byte[k] && vl == 4'd8 && k != 0) begin
        vl = 4'(8 - k);
      end
    end
    if (in_header_byte[7]) vl = 4'd1;
    vmask = 8'hFF >> vl;
    vacc  = 56'(in_header_byte & vmask);
    bias  = (64'sd1 <<< (7 * vlen_r - 1)) - 64'sd1;
    // a one-byte vint completes in the first-byte phase, bias 2^6-1
    if (phase_r == PH_VFIRST) begin
      vval = $signed({8'd0, vacc});
      vsub = 64'sd63;
    end else begin
      vval = $signed({8'd0, acc_r[47:0], in_header_byte});
      vsub = bias;
    end
    if (fpar_r == '0) begin
      vfinal = vval;
    end else begin
      vfinal = run_r + vval - vsub;
      if (vfinal > RUN_LIM) vfinal = RUN_LIM;
      if (vfinal < -RUN_LIM) vfinal = -RUN_LIM;
    end
  end

  // whether a 64-bit signed value fits as a size
  function automatic logic fits(input logic signed [63:0] v);
    return (v >= 0) && (v <= $signed({{(64 - SW){1'b0}}, LEN_MASK}));
  endfunction

  logic [SW:0] xsum;
  logic [8:0] nlaces;
  logic [SW-1:0] esz;
  logic ebad;
  logic [SW+1:0] eend;
  logic elast;

  always_comb begin
    xsum   = (SW + 1)'(acc_r) + (SW + 1)'(in_header_byte);
    if (xsum > {1'b0, LEN_MASK}) xsum = {1'b1, {SW{1'b0}}};
    nlaces = 9'(in_header_byte) + 9'd1;
    elast  = (ei_r + CW'(1) == ftot_r);
    // fixed lacing reads the quotient, not the store
    if (mode_r == MODE_FIXED) begin
      esz  = quo_r;
      ebad = 1'b0;
    end else if (!elast) begin
      esz  = rdata[SW-1:0];
      ebad = rdata[SW];
    end else begin
      ebad = off_r > {1'b0, tlen_r};
      esz  = ebad ? '0 : SW'({1'b0, tlen_r} - off_r);
    end
    eend = {1'b0, off_r} + (SW + 2)'(esz);
    if (!ebad && eend > (SW + 2)'(tlen_r)) ebad = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      mode_r    <= '0;
      tlen_r    <= '0;
      ftot_r    <= '0;
      fpar_r    <= '0;
      hlen_r    <= '0;
      acc_r     <= '0;
      vleft_r   <= '0;
      vlen_r    <= '0;
      run_r     <= '0;
      out_valid <= 1'b0;
      ei_r      <= '0;
      estep_r   <= 1'b0;
      stuck_r   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (start && !busy && !in_req_type) begin
        mode_r  <= in_lace_mode;
        tlen_r  <= SW'(in_block_len);
        hlen_r  <= '0;
        fpar_r  <= '0;
        acc_r   <= '0;
        vleft_r <= '0;
        vlen_r  <= '0;
        run_r   <= '0;
        if (in_lace_mode == MODE_NONE) begin
          ftot_r  <= CW'(1);
          ei_r    <= '0;
          estep_r <= 1'b0;
          stuck_r <= 1'b0;
          off_r   <= '0;
          phase_r <= PH_EMIT;
        end else begin
          phase_r <= PH_COUNT;
        end
      end else if (start && !busy && in_req_type && phase_r != PH_IDLE) begin
        if (phase_r != PH_COUNT && hlen_r < LEN_MASK) hlen_r <= hlen_r + SW'(1);
        case (phase_r)
          PH_COUNT: begin
            hlen_r <= SW'(1);
            if (nlaces > 9'(MAX_LACES)) begin
              phase_r <= PH_ERR;
            end else begin
              ftot_r  <= CW'(nlaces);
              ei_r    <= '0;
              estep_r <= 1'b0;
              stuck_r <= 1'b0;
              off_r   <= (SW + 1)'(1);
              if (mode_r == MODE_FIXED) begin
                dvd_r   <= (tlen_r != '0) ? tlen_r - SW'(1) : '0;
                divn_r  <= nlaces;
                rem_r   <= '0;
                dcnt_r  <= 9'(SW);
                phase_r <= PH_DIV;
              end else if (nlaces == 9'd1) begin
                phase_r <= PH_EMIT;
              end else begin
                acc_r   <= '0;
                phase_r <= (mode_r == MODE_XIPH) ? PH_XSIZE : PH_VFIRST;
              end
            end
          end
          PH_XSIZE: begin
            if (in_header_byte == XIPH_CONT) begin
              acc_r <= 56'(xsum);
            end else begin
              psize_r <= xsum[SW-1:0];
              pbad_r  <= xsum[SW];
              acc_r   <= '0;
              phase_r <= PH_STORE;
            end
          end
          PH_VFIRST: begin
            vlen_r  <= vl;
            vleft_r <= 3'(vl - 4'd1);
            acc_r   <= vacc;
            phase_r <= (vl == 4'd1) ? PH_STORE : PH_VREST;
            if (vl == 4'd1) begin
              // one-byte vint finishes at once
              run_r   <= vfinal;
              psize_r <= vfinal[SW-1:0];
              pbad_r  <= !fits(vfinal);
            end
          end
          PH_VREST: begin
            acc_r <= {acc_r[47:0], in_header_byte};
            if (vleft_r == 3'd1) begin
              run_r   <= vfinal;
              psize_r <= vfinal[SW-1:0];
              pbad_r  <= !fits(vfinal);
              phase_r <= PH_STORE;
            end
            vleft_r <= vleft_r - 3'd1;
          end
          default: ;
        endcase
      end else begin
        case (phase_r)
          PH_STORE: begin
            acc_r  <= '0;
            fpar_r <= (fpar_r < MAXL) ? fpar_r + CW'(1) : fpar_r;
            if ((CW + 1)'(fpar_r) + (CW + 1)'(2) >= (CW + 1)'(ftot_r)) begin
              // frames start right after the whole lacing header
              off_r   <= {1'b0, hlen_r};
              phase_r <= PH_EMIT;
            end else begin
              phase_r <= (mode_r == MODE_XIPH) ? PH_XSIZE : PH_VFIRST;
            end
          end
          PH_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (dcnt_r != '0) begin
              if ({rem_r, dvd_r[SW-1]} >= (SW + 1)'(divn_r)) begin
                rem_r <= SW'({rem_r, dvd_r[SW-1]} - (SW + 1)'(divn_r));
                quo_r <= {quo_r[SW-2:0], 1'b1};
              end else begin
                rem_r <= {rem_r[SW-2:0], dvd_r[SW-1]};
                quo_r <= {quo_r[SW-2:0], 1'b0};
              end
              dvd_r  <= dvd_r << 1;
              dcnt_r <= dcnt_r - 9'd1;
            end else begin
              phase_r <= PH_EMIT;
            end
          end
          PH_EMIT: begin
            if (!estep_r) begin
              estep_r <= 1'b1;
            end else begin
              estep_r <= 1'b0;
              out_valid        <= 1'b1;
              out_frame_index  <= 6'(ei_r);
              out_last         <= elast;
              if (stuck_r || ebad) begin
                stuck_r          <= 1'b1;
                out_frame_offset <= '0;
                out_frame_size   <= '0;
                out_status       <= ST_BAD;
              end else begin
                out_frame_offset <= 24'(off_r);
                out_frame_size   <= 24'(esz);
                out_status       <= ST_OK;
                off_r            <= eend[SW:0];
              end
              ei_r <= ei_r + CW'(1);
              if (elast) phase_r <= PH_IDLE;
            end
          end
          PH_ERR: begin
            out_valid        <= 1'b1;
            out_frame_index  <= '0;
            out_frame_offset <= '0;
            out_frame_size   <= '0;
            out_last         <= 1'b1;
            out_status       <= ST_TOO_MANY;
            phase_r          <= PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/blfs_checker.sv @@
// Port-level checks for the frame splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module blfs_checker
  import blfs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_req_type,
  input wire logic [1:0] in_lace_mode,
  input wire logic       out_valid,
  input wire logic [5:0] out_frame_index,
  input wire logic       out_last,
  input wire logic [1:0] out_status
);
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status code");
  a_toomany: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_MANY |-> out_last && out_frame_index == 6'd0)
    else $error("too-many result malformed");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("idle between frames");
  a_noreq: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_req_type && in_lace_mode == MODE_NONE |=> busy)
    else $error("single frame not started");
endmodule

bind block_lacing_frame_splitter blfs_checker u_blfs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req_type(in_req_type),
  .in_lace_mode(in_lace_mode), .out_valid(out_valid),
  .out_frame_index(out_frame_index), .out_last(out_last), .out_status(out_status)
);
`default_nettype wire
